// ===== src/bbhq_pkg.sv =====
// shared types and constants for the bounded binary heap queue
package bbhq_pkg;

    localparam int CAPACITY = 31;
    localparam int IDX_W = $clog2(CAPACITY + 1);
    localparam int CNT_W = $clog2(CAPACITY + 1);

    localparam logic [1:0] CMD_INSERT = 2'd0;
    localparam logic [1:0] CMD_POP = 2'd1;
    localparam logic [1:0] CMD_FIND = 2'd2;

    localparam logic [1:0] ST_OK = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_NOT_FOUND = 2'd2;
    localparam logic [1:0] ST_EVICTED = 2'd3;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] out_priority;
        logic [31:0] out_payload;
        logic [4:0]  out_index;
        logic [4:0]  out_count;
    } result_t;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [31:0] priority_req;
        logic [31:0] payload;
    } request_t;

endpackage

// ===== src/bbhq_cmp.sv =====
// shared priority comparator used by every sift and search step
module bbhq_cmp (
    input  logic        order_mode,
    input  logic [31:0] a,
    input  logic [31:0] b,
    output logic        above,
    output logic        equal
);
    import bbhq_pkg::*;

    logic signed [31:0] sa;
    logic signed [31:0] sb;

    assign sa = a;
    assign sb = b;
    assign above = order_mode ? (sa < sb) : (sa > sb);
    assign equal = (a == b);

endmodule

// ===== src/bbhq_core.sv =====
// heap storage and sequencer for insert, pop and find
module bbhq_core (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                order_mode,
    input  logic                req_valid,
    output logic                req_ready,
    input  bbhq_pkg::request_t  req,
    output logic                res_valid,
    input  logic                res_ready,
    output bbhq_pkg::result_t   res
);
    import bbhq_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_RD_LAST, S_MOVE_LAST, S_DN_RD_L, S_DN_CMP_L, S_DN_CMP_R,
        S_SWAP, S_APPEND, S_UP_CMP, S_FIND_RD, S_FIND_CMP, S_DONE
    } state_t;

    logic [31:0] prio_mem [1:CAPACITY];
    logic [31:0] pay_mem [1:CAPACITY];

    state_t             state_reg;
    logic [CNT_W-1:0]   count_reg;
    request_t           req_reg;
    result_t            res_reg;
    logic               res_valid_reg;
    logic               evict_reg;
    logic               up_reg;
    logic [IDX_W-1:0]   cur_reg;
    logic [IDX_W-1:0]   oth_reg;
    logic [IDX_W-1:0]   best_reg;
    logic [31:0]        cur_p_reg;
    logic [31:0]        cur_d_reg;
    logic [31:0]        best_p_reg;
    logic [31:0]        best_d_reg;

    logic [31:0] cmp_a;
    logic [31:0] cmp_b;
    logic        cmp_above;
    logic        cmp_equal;

    logic [IDX_W:0] left_w;
    logic [IDX_W:0] right_w;

    assign left_w = {cur_reg, 1'b0};
    assign right_w = {cur_reg, 1'b1};

    bbhq_cmp u_cmp (
        .order_mode (order_mode),
        .a          (cmp_a),
        .b          (cmp_b),
        .above      (cmp_above),
        .equal      (cmp_equal)
    );

    always_comb
    begin
        cmp_a = prio_mem[oth_reg];
        cmp_b = best_p_reg;
        if (state_reg == S_UP_CMP)
        begin
            cmp_a = cur_p_reg;
            cmp_b = prio_mem[oth_reg];
        end
        else if (state_reg == S_FIND_CMP)
        begin
            cmp_a = prio_mem[cur_reg];
            cmp_b = req_reg.priority_req;
        end
    end

    assign req_ready = (state_reg == S_IDLE) && !res_valid_reg;
    assign res_valid = res_valid_reg;
    assign res = res_reg;

    always_ff @(posedge clk)
    begin
        if (state_reg == S_MOVE_LAST)
        begin
            prio_mem[1] <= prio_mem[count_reg[IDX_W-1:0]];
            pay_mem[1] <= pay_mem[count_reg[IDX_W-1:0]];
        end
        else if (state_reg == S_SWAP)
        begin
            prio_mem[cur_reg] <= best_p_reg;
            pay_mem[cur_reg] <= best_d_reg;
            prio_mem[best_reg] <= cur_p_reg;
            pay_mem[best_reg] <= cur_d_reg;
        end
        else if (state_reg == S_APPEND)
        begin
            prio_mem[IDX_W'(count_reg + 1'b1)] <= req_reg.priority_req;
            pay_mem[IDX_W'(count_reg + 1'b1)] <= req_reg.payload;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            res_valid_reg <= 1'b0;
            req_reg <= '0;
            res_reg <= '0;
            evict_reg <= 1'b0;
            up_reg <= 1'b0;
            cur_reg <= '0;
            oth_reg <= '0;
            best_reg <= '0;
            cur_p_reg <= '0;
            cur_d_reg <= '0;
            best_p_reg <= '0;
            best_d_reg <= '0;
        end
        else
        begin
            if (res_valid_reg && res_ready)
                res_valid_reg <= 1'b0;
            case (state_reg)
                S_IDLE:
                begin
                    if (req_valid && req_ready)
                    begin
                        req_reg <= req;
                        evict_reg <= (req.cmd == CMD_INSERT)
                                     && (count_reg >= CNT_W'(CAPACITY));
                        case (req.cmd)
                            CMD_INSERT:
                            begin
                                res_reg <= '0;
                                if (count_reg >= CNT_W'(CAPACITY))
                                    state_reg <= S_RD_LAST;
                                else
                                    state_reg <= S_APPEND;
                            end
                            CMD_POP:
                            begin
                                if (count_reg == '0)
                                begin
                                    res_reg <= {ST_EMPTY, 74'd0};
                                    state_reg <= S_DONE;
                                end
                                else
                                begin
                                    res_reg <= '0;
                                    state_reg <= S_RD_LAST;
                                end
                            end
                            CMD_FIND:
                            begin
                                res_reg <= {ST_NOT_FOUND, 74'd0};
                                cur_reg <= IDX_W'(1);
                                state_reg <= S_FIND_RD;
                            end
                            default:
                            begin
                                res_reg <= '0;
                                state_reg <= S_DONE;
                            end
                        endcase
                    end
                end
                S_RD_LAST:
                begin
                    res_reg.out_priority <= prio_mem[1];
                    res_reg.out_payload <= pay_mem[1];
                    state_reg <= S_MOVE_LAST;
                end
                S_MOVE_LAST:
                begin
                    cur_p_reg <= prio_mem[count_reg[IDX_W-1:0]];
                    cur_d_reg <= pay_mem[count_reg[IDX_W-1:0]];
                    count_reg <= count_reg - 1'b1;
                    cur_reg <= IDX_W'(1);
                    up_reg <= 1'b0;
                    state_reg <= S_DN_RD_L;
                end
                S_DN_RD_L:
                begin
                    best_reg <= cur_reg;
                    best_p_reg <= cur_p_reg;
                    best_d_reg <= cur_d_reg;
                    if (left_w <= {1'b0, count_reg})
                    begin
                        oth_reg <= left_w[IDX_W-1:0];
                        state_reg <= S_DN_CMP_L;
                    end
                    else
                        state_reg <= evict_reg ? S_APPEND : S_DONE;
                end
                S_DN_CMP_L:
                begin
                    if (cmp_above)
                    begin
                        best_reg <= oth_reg;
                        best_p_reg <= prio_mem[oth_reg];
                        best_d_reg <= pay_mem[oth_reg];
                    end
                    if (right_w <= {1'b0, count_reg})
                    begin
                        oth_reg <= right_w[IDX_W-1:0];
                        state_reg <= S_DN_CMP_R;
                    end
                    else if (cmp_above)
                        state_reg <= S_SWAP;
                    else
                        state_reg <= evict_reg ? S_APPEND : S_DONE;
                end
                S_DN_CMP_R:
                begin
                    if (cmp_above)
                    begin
                        best_reg <= oth_reg;
                        best_p_reg <= prio_mem[oth_reg];
                        best_d_reg <= pay_mem[oth_reg];
                        state_reg <= S_SWAP;
                    end
                    else if (best_reg != cur_reg)
                        state_reg <= S_SWAP;
                    else
                        state_reg <= evict_reg ? S_APPEND : S_DONE;
                end
                S_SWAP:
                begin
                    cur_reg <= best_reg;
                    if (up_reg)
                    begin
                        if (best_reg > IDX_W'(1))
                        begin
                            oth_reg <= best_reg >> 1;
                            state_reg <= S_UP_CMP;
                        end
                        else
                            state_reg <= S_DONE;
                    end
                    else
                        state_reg <= S_DN_RD_L;
                end
                S_APPEND:
                begin
                    count_reg <= count_reg + 1'b1;
                    cur_reg <= IDX_W'(count_reg + 1'b1);
                    cur_p_reg <= req_reg.priority_req;
                    cur_d_reg <= req_reg.payload;
                    up_reg <= 1'b1;
                    if (evict_reg)
                        res_reg.status <= ST_EVICTED;
                    if (count_reg + 1'b1 > CNT_W'(1))
                    begin
                        oth_reg <= IDX_W'(count_reg + 1'b1) >> 1;
                        state_reg <= S_UP_CMP;
                    end
                    else
                        state_reg <= S_DONE;
                end
                S_UP_CMP:
                begin
                    if (cmp_above)
                    begin
                        best_reg <= oth_reg;
                        best_p_reg <= prio_mem[oth_reg];
                        best_d_reg <= pay_mem[oth_reg];
                        state_reg <= S_SWAP;
                    end
                    else
                        state_reg <= S_DONE;
                end
                S_FIND_RD:
                begin
                    if ({1'b0, cur_reg} <= {1'b0, count_reg} && cur_reg != '0)
                        state_reg <= S_FIND_CMP;
                    else
                        state_reg <= S_DONE;
                end
                S_FIND_CMP:
                begin
                    if (cmp_equal)
                    begin
                        res_reg.status <= ST_OK;
                        res_reg.out_index <= 5'(cur_reg);
                        state_reg <= S_DONE;
                    end
                    else
                    begin
                        cur_reg <= cur_reg + 1'b1;
                        state_reg <= S_FIND_RD;
                    end
                end
                S_DONE:
                begin
                    res_reg.out_count <= 5'(count_reg);
                    res_valid_reg <= 1'b1;
                    state_reg <= S_IDLE;
                end
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

endmodule

// ===== src/bounded_binary_heap_queue.sv =====
// top level of the bounded binary heap priority queue
// usage:
//   s_axis carries one command item: insert, pop root or find priority.
//   m_axis returns exactly one result item per command, in order.
//   cfg_valid/cfg_ready writes order_mode (0 max-heap, 1 min-heap); write
//   it only while the block is idle.
// timing:
//   a command is taken only when the sequencer is idle and the result
//   register is empty; it then runs on one shared comparator.
//   pop reads the root, moves the last slot to the root and walks the tree
//   down, comparing each node with its children and swapping; insert appends
//   and walks up, comparing with the parent; a full insert does both.
//   find scans occupied slots one by one, in index order, until a match.
// reset:
//   the heap is empty and the mode is max-heap; slot contents are not
//   cleared, only occupied slots are ever read.
// stalls:
//   a result waits in its register until m_axis_tready; no new command is
//   taken meanwhile.
module bounded_binary_heap_queue (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [71:0] s_axis_tdata,  // cmd, priority_req, payload, zero pad
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [79:0] m_axis_tdata,  // status, out_priority, out_payload,
                                       // out_index, out_count, zero pad
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [0:0]  cfg_data       // order_mode
);
    import bbhq_pkg::*;

    logic     mode_reg;
    request_t req;
    result_t  res;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            mode_reg <= 1'b0;
        else if (cfg_valid)
            mode_reg <= cfg_data[0];
    end

    assign req.cmd = s_axis_tdata[1:0];
    assign req.priority_req = s_axis_tdata[33:2];
    assign req.payload = s_axis_tdata[65:34];

    assign m_axis_tdata = {4'd0, res.out_count, res.out_index, res.out_payload,
                           res.out_priority, res.status};

    bbhq_core u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .order_mode (mode_reg),
        .req_valid  (s_axis_tvalid),
        .req_ready  (s_axis_tready),
        .req        (req),
        .res_valid  (m_axis_tvalid),
        .res_ready  (m_axis_tready),
        .res        (res)
    );

endmodule

// ===== bench/heap_queue_checker.sv =====
// checker for the bounded binary heap queue: predicts each result and compares
module heap_queue_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [71:0] s_axis_tdata,
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [79:0] m_axis_tdata,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [0:0]  cfg_data,
    output int          fail_count,
    output int          pending
);
    import bbhq_pkg::*;

    logic [31:0] heap_prio [1:CAPACITY];
    logic [31:0] heap_pay [1:CAPACITY];
    int          heap_size;
    logic        min_mode;
    result_t     expected_results[$];

    function automatic bit outranks(logic [31:0] a, logic [31:0] b);
        if (min_mode)
            return $signed(a) < $signed(b);
        return $signed(a) > $signed(b);
    endfunction

    task automatic swap_entries(int i, int j);
        logic [31:0] t;
        t = heap_prio[i]; heap_prio[i] = heap_prio[j]; heap_prio[j] = t;
        t = heap_pay[i]; heap_pay[i] = heap_pay[j]; heap_pay[j] = t;
    endtask

    task automatic take_root(output logic [31:0] pr, output logic [31:0] pl);
        int i;
        int best;
        pr = heap_prio[1];
        pl = heap_pay[1];
        heap_prio[1] = heap_prio[heap_size];
        heap_pay[1] = heap_pay[heap_size];
        heap_size--;
        i = 1;
        while (i <= heap_size)
        begin
            best = i;
            if (2 * i <= heap_size && outranks(heap_prio[2 * i], heap_prio[best]))
                best = 2 * i;
            if (2 * i + 1 <= heap_size && outranks(heap_prio[2 * i + 1], heap_prio[best]))
                best = 2 * i + 1;
            if (best == i)
                break;
            swap_entries(i, best);
            i = best;
        end
    endtask

    task automatic apply_request(request_t req, output result_t res);
        int i;
        res = '0;
        res.status = ST_OK;
        if (req.cmd == CMD_INSERT)
        begin
            if (heap_size >= CAPACITY)
            begin
                take_root(res.out_priority, res.out_payload);
                res.status = ST_EVICTED;
            end
            heap_size++;
            heap_prio[heap_size] = req.priority_req;
            heap_pay[heap_size] = req.payload;
            i = heap_size;
            while (i > 1 && outranks(heap_prio[i], heap_prio[i / 2]))
            begin
                swap_entries(i, i / 2);
                i = i / 2;
            end
        end
        else if (req.cmd == CMD_POP)
        begin
            if (heap_size == 0)
                res.status = ST_EMPTY;
            else
                take_root(res.out_priority, res.out_payload);
        end
        else if (req.cmd == CMD_FIND)
        begin
            res.status = ST_NOT_FOUND;
            for (i = 1; i <= heap_size; i++)
            begin
                if (heap_prio[i] == req.priority_req)
                begin
                    res.status = ST_OK;
                    res.out_index = i[4:0];
                    break;
                end
            end
        end
        res.out_count = heap_size[4:0];
    endtask

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch %s: got %0h expected %0h", what, got, want);
        fail_count++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        result_t res;
        result_t got;
        request_t req;
        if (!rst_n)
        begin
            heap_size = 0;
            min_mode = 1'b0;
            fail_count = 0;
            expected_results.delete();
            pending = 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                min_mode = cfg_data[0];
            if (s_axis_tvalid && s_axis_tready)
            begin
                // tdata packs cmd in the lowest bits
                req.cmd = s_axis_tdata[1:0];
                req.priority_req = s_axis_tdata[33:2];
                req.payload = s_axis_tdata[65:34];
                apply_request(req, res);
                expected_results.push_back(res);
            end
            if (m_axis_tvalid && m_axis_tready)
            begin
                got.status = m_axis_tdata[1:0];
                got.out_priority = m_axis_tdata[33:2];
                got.out_payload = m_axis_tdata[65:34];
                got.out_index = m_axis_tdata[70:66];
                got.out_count = m_axis_tdata[75:71];
                if (expected_results.size() == 0)
                begin
                    report_mismatch("unexpected item", 32'(got.status), 32'd0);
                end
                else
                begin
                    res = expected_results.pop_front();
                    if (got.status !== res.status)
                        report_mismatch("status", 32'(got.status), 32'(res.status));
                    if (got.out_priority !== res.out_priority)
                        report_mismatch("priority", got.out_priority, res.out_priority);
                    if (got.out_payload !== res.out_payload)
                        report_mismatch("payload", got.out_payload, res.out_payload);
                    if (got.out_index !== res.out_index)
                        report_mismatch("index", 32'(got.out_index), 32'(res.out_index));
                    if (got.out_count !== res.out_count)
                        report_mismatch("count", 32'(got.out_count), 32'(res.out_count));
                end
            end
            pending = expected_results.size();
        end
    end

endmodule

// ===== bench/testbench.sv =====
// top of the heap queue testbench: clock, reset, stimulus and verdict
module testbench;
    import bbhq_pkg::*;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [71:0] s_axis_tdata;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [79:0] m_axis_tdata;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [0:0]  cfg_data;
    int          fail_count;
    int          pending;
    int          idle_cycles;
    bit          hold_off;
    bit          stall_random;

    logic [31:0] recent_keys[$];

    bounded_binary_heap_queue dut (
        .clk(clk), .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
    );

    heap_queue_checker checker_i (
        .clk(clk), .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
        .fail_count(fail_count), .pending(pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // receiver: random stalls, long hold-off on request
    initial
    begin
        m_axis_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_off)
                m_axis_tready <= 1'b0;
            else if (stall_random)
                m_axis_tready <= ($urandom_range(0, 3) != 0);
            else
                m_axis_tready <= 1'b1;
        end
    end

    initial
    begin
        idle_cycles = 0;
        forever
        begin
            @(posedge clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
                || hold_off)
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles > 5000)
            begin
                $display("bounded_binary_heap_queue regression: fail");
                $finish;
            end
        end
    end

    task automatic send_item(logic [1:0] cmd, logic [31:0] key, logic [31:0] val);
        s_axis_tdata <= {6'd0, val, key, cmd};
        s_axis_tvalid <= 1'b1;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        @(negedge clk);
        if (cmd == CMD_INSERT)
        begin
            recent_keys.push_back(key);
            if (recent_keys.size() > 40)
                void'(recent_keys.pop_front());
        end
    endtask

    task automatic gap();
        s_axis_tvalid <= 1'b0;
        repeat ($urandom_range(1, 6))
            @(negedge clk);
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        @(negedge clk);
        while (pending != 0)
            @(negedge clk);
        repeat (80)
            @(negedge clk);
    endtask

    task automatic write_mode(logic mode);
        cfg_data <= mode;
        cfg_valid <= 1'b1;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [31:0] pick_key();
        int sel;
        sel = $urandom_range(0, 9);
        if (sel == 0)
            return 32'h8000_0000;
        if (sel == 1)
            return 32'h7fff_ffff;
        if (sel < 5)
            return $urandom_range(0, 15) - 8;
        return $urandom;
    endfunction

    task automatic random_phase(int count, int insert_bias);
        int n;
        int burst;
        logic [1:0] cmd;
        logic [31:0] key;
        n = 0;
        while (n < count)
        begin
            burst = $urandom_range(1, 12);
            repeat (burst)
            begin
                if ($urandom_range(0, 99) < insert_bias)
                    cmd = CMD_INSERT;
                else if ($urandom_range(0, 2) == 0)
                    cmd = CMD_FIND;
                else
                    cmd = CMD_POP;
                if ($urandom_range(0, 60) == 0)
                    cmd = 2'd3;
                key = pick_key();
                if (cmd == CMD_FIND && recent_keys.size() > 0 && $urandom_range(0, 1))
                    key = recent_keys[$urandom_range(0, recent_keys.size() - 1)];
                send_item(cmd, key, $urandom);
                n++;
            end
            if ($urandom_range(0, 2) != 0)
                gap();
        end
    endtask

    initial
    begin
        int i;
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        cfg_valid = 1'b0;
        cfg_data = 1'b0;
        hold_off = 1'b0;
        stall_random = 1'b0;
        repeat (11)
            @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: empty pop, extremes, find miss and hit, unused code
        send_item(CMD_POP, 32'd0, 32'd0);
        send_item(CMD_FIND, 32'd5, 32'd0);
        send_item(CMD_INSERT, 32'h7fff_ffff, 32'hffff_ffff);
        send_item(CMD_INSERT, 32'h8000_0000, 32'h0000_0000);
        send_item(CMD_INSERT, 32'd0, 32'h8000_0000);
        send_item(CMD_INSERT, 32'd0, 32'h7fff_ffff);
        send_item(CMD_FIND, 32'h8000_0000, 32'd0);
        send_item(CMD_FIND, 32'd1, 32'd0);
        send_item(2'd3, 32'hffff_ffff, 32'hffff_ffff);
        send_item(CMD_POP, 32'd0, 32'd0);
        send_item(CMD_POP, 32'd0, 32'd0);
        drain();
        write_mode(1'b1);
        // fill past capacity in min mode to force evictions
        for (i = 0; i < 34; i++)
            send_item(CMD_INSERT, i % 5 - 2, i);
        send_item(CMD_FIND, 32'd2, 32'd0);
        drain();
        write_mode(1'b0);
        send_item(CMD_POP, 32'd0, 32'd0);
        send_item(CMD_INSERT, 32'd100, 32'd1);
        drain();

        // random with stalls, back-pressure hold-off in the middle
        stall_random = 1'b1;
        random_phase(120, 50);
        drain();
        write_mode(1'b1);
        fork
            begin
                hold_off = 1'b1;
                repeat (400)
                    @(negedge clk);
                hold_off = 1'b0;
            end
            random_phase(150, 70);
        join
        drain();
        write_mode(1'b0);
        random_phase(150, 60);
        drain();
        write_mode(1'b1);
        random_phase(80, 40);
        drain();

        if (fail_count == 0)
            $display("bounded_binary_heap_queue regression: pass");
        else
            $display("bounded_binary_heap_queue regression: fail");
        $finish;
    end

endmodule
